// ===== rtl/fjot_pkg.sv =====
package fjot_pkg;

	localparam int INDEX_BITS      = 16;
	localparam int MAX_FRAC_DIGITS = 9;
	localparam int POS_BITS        = 16;

	// result kinds
	localparam logic [2:0] K_KEY_CHAR = 3'd0;
	localparam logic [2:0] K_KEY_END  = 3'd1;
	localparam logic [2:0] K_STR_CHAR = 3'd2;
	localparam logic [2:0] K_STR_END  = 3'd3;
	localparam logic [2:0] K_INT      = 3'd4;
	localparam logic [2:0] K_FLOAT    = 3'd5;
	localparam logic [2:0] K_DONE     = 3'd6;
	localparam logic [2:0] K_ERROR    = 3'd7;

	// character codes
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// result tdata layout, lowest bit up
	localparam int TD_CHAR_LO  = 0;
	localparam int TD_INT_LO   = 8;
	localparam int TD_FRAC_LO  = 40;
	localparam int TD_DIG_LO   = 70;
	localparam int TD_NEG      = 74;
	localparam int TD_POS_LO   = 75;
	localparam int TD_USED     = 91;
	localparam int TD_BITS     = 96;

	typedef struct packed {
		logic [2:0]          kind;
		logic [7:0]          char_byte;
		logic signed [31:0]  int_value;
		logic [29:0]         frac_value;
		logic [3:0]          frac_digits;
		logic                is_negative;
		logic [POS_BITS-1:0] position;
		logic                run_last;
	} res_t;

	typedef struct packed {
		logic [2:0]            mode;
		logic                  esc;
		logic                  expv;
		logic [31:0]           iacc;
		logic [29:0]           facc;
		logic [3:0]            fcnt;
		logic                  neg;
		logic                  flt;
		logic [INDEX_BITS-1:0] idx;
	} state_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} step_t;

endpackage

// ===== rtl/flat_json_object_tokenizer.sv =====
// Tokenizer for a flat JSON object, one text byte per input item with tlast on the
// buffer's final byte. Each accepted byte yields zero, one or two result items
// (tuser = kind, tlast = last result of that byte). A byte is registered, decoded
// combinationally and its results land in a two-entry output buffer, so a new byte is
// taken every cycle as long as results drain; a byte that gives two results holds
// the input while both wait in the output buffer. No clearing pass after reset.
module flat_json_object_tokenizer import fjot_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // data_byte
	input  logic               s_tlast,   // last_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TD_BITS-1:0] m_tdata,   // char_byte, int_value, frac_value,
	                                      // frac_digits, is_negative, position
	output logic [2:0]         m_tuser,   // kind
	output logic               m_tlast    // run_last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	state_t     st_q;
	state_t     st_nx;
	step_t      step;
	res_t       out0_q;
	res_t       out1_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic       proc;

	fjot_step u_step (
		.st        (st_q),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.nx        (st_nx),
		.res       (step)
	);

	assign pop      = m_tvalid && m_tready;
	assign proc     = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
	assign s_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			cnt_q <= 2'd0;
		end else if (proc) begin
			st_q  <= st_nx;
			cnt_q <= step.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			out0_q <= step.r0;
			out1_q <= step.r1;
		end else if (pop) begin
			out0_q <= out1_q;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tuser  = out0_q.kind;
	assign m_tlast  = out0_q.run_last;
	assign m_tdata  = {(TD_BITS - TD_USED)'(0), out0_q.position, out0_q.is_negative,
		out0_q.frac_digits, out0_q.frac_value, out0_q.int_value, out0_q.char_byte};

endmodule

// ===== rtl/fjot_step.sv =====
module fjot_step import fjot_pkg::*; (
	input  state_t     st,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output state_t     nx,
	output step_t      res
);

	localparam logic [2:0] MODE_BRACE    = 3'd0;
	localparam logic [2:0] MODE_OBJECT   = 3'd1;
	localparam logic [2:0] MODE_STRING   = 3'd2;
	localparam logic [2:0] MODE_NUMBER   = 3'd3;
	localparam logic [2:0] MODE_FINISHED = 3'd4;

	logic        is_dig;
	logic        is_ws;
	logic [3:0]  dgt;
	logic [31:0] iacc_next;
	logic [29:0] facc_next;
	logic [31:0] signed_iv;
	logic        pri_v;
	logic        sec_v;
	logic        fail_v;
	res_t        pri;
	res_t        sec;
	res_t        fail_tok;
	state_t      mid;

	assign is_dig    = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign is_ws     = (data_byte == CH_SPACE) || (data_byte == CH_LF) || (data_byte == CH_TAB);
	assign dgt       = 4'(data_byte - CH_ZERO);
	// times ten as two shifted adds
	assign iacc_next = {st.iacc[28:0], 3'b000} + {st.iacc[30:0], 1'b0} + 32'(dgt);
	assign facc_next = {st.facc[26:0], 3'b000} + {st.facc[28:0], 1'b0} + 30'(dgt);
	assign signed_iv = st.neg ? (32'd0 - st.iacc) : st.iacc;

	always_comb begin
		mid   = st;
		pri_v = 1'b0;
		sec_v = 1'b0;
		pri   = '0;
		sec   = '0;
		unique case (st.mode)
			MODE_BRACE: begin
				if (data_byte == CH_LBRACE) begin
					mid.mode = MODE_OBJECT;
					mid.expv = 1'b0;
				end else begin
					pri_v    = 1'b1;
					pri.kind = K_ERROR;
					mid.mode = MODE_FINISHED;
				end
			end
			MODE_OBJECT: begin
				if (is_ws) begin
					mid = st;
				end else if (data_byte == CH_RBRACE) begin
					pri_v        = 1'b1;
					pri.kind     = K_DONE;
					pri.position = POS_BITS'(st.idx);
					mid.mode     = MODE_FINISHED;
				end else if (!st.expv) begin
					if (data_byte == CH_QUOTE) begin
						mid.mode = MODE_STRING;
						mid.esc  = 1'b0;
					end else if (data_byte == CH_COLON) begin
						pri_v    = 1'b1;
						pri.kind = K_ERROR;
						mid.mode = MODE_FINISHED;
					end
				end else if (data_byte == CH_COLON) begin
					mid = st;
				end else if (data_byte == CH_QUOTE) begin
					mid.mode = MODE_STRING;
					mid.esc  = 1'b0;
				end else if (data_byte == CH_MINUS || is_dig) begin
					// fresh number, first byte already taken in
					mid.mode = MODE_NUMBER;
					mid.iacc = is_dig ? 32'(dgt) : 32'd0;
					mid.facc = '0;
					mid.fcnt = '0;
					mid.neg  = (data_byte == CH_MINUS);
					mid.flt  = 1'b0;
				end else begin
					pri_v    = 1'b1;
					pri.kind = K_ERROR;
					mid.mode = MODE_FINISHED;
				end
			end
			MODE_STRING: begin
				if (st.esc) begin
					mid.esc       = 1'b0;
					pri_v         = 1'b1;
					pri.kind      = st.expv ? K_STR_CHAR : K_KEY_CHAR;
					pri.char_byte = data_byte;
				end else if (data_byte == CH_BSLASH) begin
					mid.esc = 1'b1;
				end else if (data_byte == CH_QUOTE) begin
					pri_v    = 1'b1;
					pri.kind = st.expv ? K_STR_END : K_KEY_END;
					mid.expv = !st.expv;
					mid.mode = MODE_OBJECT;
				end else begin
					pri_v         = 1'b1;
					pri.kind      = st.expv ? K_STR_CHAR : K_KEY_CHAR;
					pri.char_byte = data_byte;
				end
			end
			MODE_NUMBER: begin
				if (is_dig) begin
					if (!st.flt) begin
						mid.iacc = iacc_next;
					end else if (st.fcnt < 4'(MAX_FRAC_DIGITS)) begin
						mid.facc = facc_next;
						mid.fcnt = st.fcnt + 4'd1;
					end
				end else if (data_byte == CH_DOT) begin
					mid.flt = 1'b1;
				end else if (data_byte == CH_MINUS) begin
					mid.neg = 1'b1;
				end else if (data_byte == CH_COMMA || data_byte == CH_RBRACE ||
						data_byte == CH_SPACE) begin
					pri_v           = 1'b1;
					pri.kind        = st.flt ? K_FLOAT : K_INT;
					pri.int_value   = signed_iv;
					pri.frac_value  = st.flt ? st.facc : 30'd0;
					pri.frac_digits = st.flt ? st.fcnt : 4'd0;
					pri.is_negative = st.neg;
					mid.iacc        = '0;
					mid.facc        = '0;
					mid.fcnt        = '0;
					mid.neg         = 1'b0;
					mid.flt         = 1'b0;
					mid.expv        = 1'b0;
					mid.mode        = MODE_OBJECT;
					// closing brace ends the object right after the number
					if (data_byte == CH_RBRACE) begin
						sec_v        = 1'b1;
						sec.kind     = K_DONE;
						sec.position = POS_BITS'(st.idx);
						mid.mode     = MODE_FINISHED;
					end
				end else begin
					mid.iacc = '0;
					mid.facc = '0;
					mid.fcnt = '0;
					mid.neg  = 1'b0;
					mid.flt  = 1'b0;
					pri_v    = 1'b1;
					pri.kind = K_ERROR;
					mid.mode = MODE_FINISHED;
				end
			end
			default: begin
				mid = st;
			end
		endcase
		mid.idx = st.idx + INDEX_BITS'(1);
	end

	// buffer ends without done or error
	assign fail_v = last_byte && (mid.mode != MODE_FINISHED) && (mid.mode <= MODE_NUMBER);

	always_comb begin
		fail_tok      = '0;
		fail_tok.kind = K_ERROR;
		res.cnt       = 2'(pri_v) + 2'(sec_v) + 2'(fail_v);
		res.r0        = pri_v ? pri : fail_tok;
		res.r1        = sec_v ? sec : fail_tok;
		res.r0.run_last = (res.cnt == 2'd1);
		res.r1.run_last = (res.cnt == 2'd2);
		if (last_byte) begin
			nx      = '0;
			nx.mode = MODE_BRACE;
		end else begin
			nx = mid;
		end
	end

endmodule

// ===== rtl/fjot_checker.sv =====
module fjot_checker import fjot_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TD_BITS-1:0] m_tdata,
	input logic [2:0]         m_tuser,
	input logic               m_tlast
);

	logic is_char;

	assign is_char = (m_tuser == K_KEY_CHAR) || (m_tuser == K_STR_CHAR);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// done and error always close the results of their byte
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == K_DONE || m_tuser == K_ERROR) |-> m_tlast)
		else $error("done or error not last of its byte");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !is_char |-> m_tdata[TD_CHAR_LO +: 8] == 8'd0)
		else $error("char byte set on non-char kind");

	a_int_frac: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == K_INT |-> m_tdata[TD_FRAC_LO +: 34] == 34'd0)
		else $error("fraction set on integer item");

	a_float_dig: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == K_FLOAT |-> m_tdata[TD_DIG_LO +: 4] <= 4'(MAX_FRAC_DIGITS))
		else $error("too many fraction digits");

endmodule

bind flat_json_object_tokenizer fjot_checker u_fjot_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import fjot_pkg::*;

	typedef enum logic [2:0] {
		P_BRACE,
		P_OBJECT,
		P_STRING,
		P_NUMBER,
		P_FINISHED
	} scan_mode_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        l;
		logic        fixed;
		logic [2:0]  kind;
		logic [15:0] pos;
	} stim_row_t;

	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_SEVEN    = 8'h37;
	localparam logic [7:0] CH_FIVE     = 8'h35;
	localparam int         DIR_ROWS    = 28;
	localparam int         PHASE_ITEMS = 165;
	localparam int         DRAIN_CYCLES = 8;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // data_byte
	logic               s_tlast;   // last_byte
	logic               m_tvalid;
	logic               m_tready;
	logic [TD_BITS-1:0] m_tdata;   // char_byte, int_value, frac_value, frac_digits,
	                               // is_negative, position
	logic [2:0]         m_tuser;   // kind
	logic               m_tlast;   // run_last

	flat_json_object_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// tokenizer state mirror
	scan_mode_t            sc_mode;
	logic                  sc_esc;
	logic                  sc_want_value;
	logic [31:0]           sc_int;
	logic [29:0]           sc_frac;
	logic [3:0]            sc_frac_cnt;
	logic                  sc_neg;
	logic                  sc_float;
	logic [INDEX_BITS-1:0] sc_index;

	res_t       byte_tokens[$];
	res_t       pending_tokens[$];
	logic [7:0] text_buf[$];

	int fail_count = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_left = 0;

	stim_row_t dir_tab [0:DIR_ROWS-1] = '{
		// bad first byte, then junk up to the end of the buffer
		'{CH_LOWER_A, 1'b0, 1'b1, K_ERROR, 16'd0},
		'{8'hFF,      1'b1, 1'b0, K_ERROR, 16'd0},
		// escaped quote and high byte in a key, negative float value
		'{CH_LBRACE,  1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_TAB,     1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_QUOTE,   1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_BSLASH,  1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_QUOTE,   1'b0, 1'b0, K_ERROR, 16'd0},
		'{8'hFF,      1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_QUOTE,   1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_COLON,   1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_MINUS,   1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_DOT,     1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_FIVE,    1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_COMMA,   1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_RBRACE,  1'b1, 1'b1, K_DONE,  16'd12},
		// colon in key position
		'{CH_LBRACE,  1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_COLON,   1'b0, 1'b1, K_ERROR, 16'd0},
		'{8'h80,      1'b1, 1'b0, K_ERROR, 16'd0},
		// buffer ends inside a number
		'{CH_LBRACE,  1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_QUOTE,   1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_QUOTE,   1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_SEVEN,   1'b1, 1'b1, K_ERROR, 16'd0},
		// bad byte in value position
		'{CH_LBRACE,  1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_QUOTE,   1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_QUOTE,   1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_LF,      1'b0, 1'b0, K_ERROR, 16'd0},
		'{CH_LBRACKET, 1'b0, 1'b1, K_ERROR, 16'd0},
		'{8'h00,      1'b1, 1'b0, K_ERROR, 16'd0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic res_t make_token(logic [2:0] k, logic [15:0] p);
		res_t r;
		r = '0;
		r.kind = k;
		r.position = p;
		r.run_last = 1'b1;
		return r;
	endfunction

	function automatic void add_token(logic [2:0] k, logic [7:0] c, logic [31:0] iv,
			logic [29:0] fv, logic [3:0] fd, logic ng, logic [15:0] p);
		res_t r;
		if (byte_tokens.size() >= 2)
			return;
		r = '0;
		r.kind = k;
		r.char_byte = c;
		r.int_value = iv;
		r.frac_value = fv;
		r.frac_digits = fd;
		r.is_negative = ng;
		r.position = p;
		byte_tokens.push_back(r);
	endfunction

	function automatic void raise_error();
		add_token(K_ERROR, 8'd0, 32'd0, 30'd0, 4'd0, 1'b0, 16'd0);
		sc_mode = P_FINISHED;
	endfunction

	function automatic void clear_number();
		sc_int = '0;
		sc_frac = '0;
		sc_frac_cnt = '0;
		sc_neg = 1'b0;
		sc_float = 1'b0;
	endfunction

	function automatic void reset_scanner();
		sc_mode = P_BRACE;
		sc_esc = 1'b0;
		sc_want_value = 1'b0;
		clear_number();
		sc_index = '0;
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic void scan_object(logic [7:0] b);
		if (b == CH_SPACE || b == CH_LF || b == CH_TAB)
			return;
		if (b == CH_RBRACE) begin
			add_token(K_DONE, 8'd0, 32'd0, 30'd0, 4'd0, 1'b0, 16'(sc_index));
			sc_mode = P_FINISHED;
			return;
		end
		if (!sc_want_value) begin
			if (b == CH_QUOTE) begin
				sc_mode = P_STRING;
				sc_esc = 1'b0;
			end else if (b == CH_COLON) begin
				raise_error();
			end
			return;
		end
		if (b == CH_COLON)
			return;
		if (b == CH_QUOTE) begin
			sc_mode = P_STRING;
			sc_esc = 1'b0;
		end else if (b == CH_MINUS || is_digit(b)) begin
			clear_number();
			sc_mode = P_NUMBER;
			scan_number(b);
		end else begin
			raise_error();
		end
	endfunction

	function automatic void scan_number(logic [7:0] b);
		logic [31:0] signed_int;
		if (is_digit(b)) begin
			if (!sc_float) begin
				sc_int = sc_int * 32'd10 + 32'(b - CH_ZERO);
			end else if (sc_frac_cnt < MAX_FRAC_DIGITS) begin
				sc_frac = sc_frac * 30'd10 + 30'(b - CH_ZERO);
				sc_frac_cnt = sc_frac_cnt + 4'd1;
			end
		end else if (b == CH_DOT) begin
			sc_float = 1'b1;
		end else if (b == CH_MINUS) begin
			sc_neg = 1'b1;
		end else if (b == CH_COMMA || b == CH_RBRACE || b == CH_SPACE) begin
			signed_int = sc_neg ? 32'd0 - sc_int : sc_int;
			if (sc_float)
				add_token(K_FLOAT, 8'd0, signed_int, sc_frac, sc_frac_cnt, sc_neg, 16'd0);
			else
				add_token(K_INT, 8'd0, signed_int, 30'd0, 4'd0, sc_neg, 16'd0);
			clear_number();
			sc_want_value = 1'b0;
			sc_mode = P_OBJECT;
			scan_object(b);
		end else begin
			clear_number();
			raise_error();
		end
	endfunction

	function automatic void scan_string(logic [7:0] b);
		logic [2:0] char_kind;
		char_kind = sc_want_value ? K_STR_CHAR : K_KEY_CHAR;
		if (sc_esc) begin
			sc_esc = 1'b0;
			add_token(char_kind, b, 32'd0, 30'd0, 4'd0, 1'b0, 16'd0);
		end else if (b == CH_BSLASH) begin
			sc_esc = 1'b1;
		end else if (b == CH_QUOTE) begin
			add_token(sc_want_value ? K_STR_END : K_KEY_END, 8'd0, 32'd0, 30'd0, 4'd0,
				1'b0, 16'd0);
			sc_want_value = !sc_want_value;
			sc_mode = P_OBJECT;
		end else begin
			add_token(char_kind, b, 32'd0, 30'd0, 4'd0, 1'b0, 16'd0);
		end
	endfunction

	// fills byte_tokens with the tokens that one byte yields
	function automatic void tokenize_byte(logic [7:0] b, logic l);
		byte_tokens.delete();
		case (sc_mode)
			P_BRACE: begin
				if (b == CH_LBRACE) begin
					sc_mode = P_OBJECT;
					sc_want_value = 1'b0;
				end else begin
					raise_error();
				end
			end
			P_OBJECT: begin
				scan_object(b);
			end
			P_STRING: begin
				scan_string(b);
			end
			P_NUMBER: begin
				scan_number(b);
			end
			default: begin
			end
		endcase
		sc_index = sc_index + INDEX_BITS'(1);
		if (l) begin
			if (sc_mode != P_FINISHED)
				raise_error();
			reset_scanner();
		end
		if (byte_tokens.size() > 0)
			byte_tokens[byte_tokens.size()-1].run_last = 1'b1;
	endfunction

	// called on a falling edge, returns on a falling edge
	task automatic send_byte(input logic [7:0] b, input logic l, input logic use_fixed,
			input res_t fixed_tok);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		tokenize_byte(b, l);
		if (use_fixed) begin
			pending_tokens.push_back(fixed_tok);
		end else begin
			foreach (byte_tokens[i])
				pending_tokens.push_back(byte_tokens[i]);
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic push_ws(input logic only_space);
		int pick;
		repeat ($urandom_range(0, 2)) begin
			pick = $urandom_range(0, 2);
			if (only_space || pick == 0)
				text_buf.push_back(CH_SPACE);
			else
				text_buf.push_back(pick == 1 ? CH_TAB : CH_LF);
		end
	endtask

	task automatic push_string();
		logic [7:0] c;
		text_buf.push_back(CH_QUOTE);
		repeat ($urandom_range(0, 5)) begin
			if ($urandom_range(0, 4) == 0) begin
				text_buf.push_back(CH_BSLASH);
				text_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
				text_buf.push_back(c);
			end
		end
		text_buf.push_back(CH_QUOTE);
	endtask

	task automatic push_number();
		if ($urandom_range(0, 1))
			text_buf.push_back(CH_MINUS);
		repeat ($urandom_range(1, 12))
			text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 9) < 4) begin
			text_buf.push_back(CH_DOT);
			repeat ($urandom_range(0, 12))
				text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			// a stray second dot or minus inside the fraction
			if ($urandom_range(0, 9) == 0) begin
				text_buf.push_back($urandom_range(0, 1) ? CH_DOT : CH_MINUS);
				repeat ($urandom_range(0, 4))
					text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
		end
	endtask

	task automatic build_buffer();
		int members;
		int roll;
		logic num_value;
		text_buf.delete();
		text_buf.push_back(CH_LBRACE);
		push_ws(1'b0);
		members = $urandom_range(0, 4);
		for (int m = 0; m < members; m++) begin
			if (m > 0) begin
				text_buf.push_back(CH_COMMA);
				push_ws(1'b0);
			end
			push_string();
			push_ws(1'b0);
			text_buf.push_back(CH_COLON);
			push_ws(1'b0);
			num_value = 1'($urandom_range(0, 1));
			if (num_value)
				push_number();
			else
				push_string();
			// only a space may follow a number
			push_ws(num_value);
		end
		text_buf.push_back(CH_RBRACE);
		if ($urandom_range(0, 3) == 0)
			push_ws(1'b0);
		roll = $urandom_range(0, 99);
		if (roll < 20) begin
			text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (roll < 30) begin
			text_buf = text_buf[0:$urandom_range(0, text_buf.size() - 1)];
		end else if (roll < 36) begin
			text_buf.delete();
			repeat ($urandom_range(1, 6))
				text_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_buffer(inout int sent);
		foreach (text_buf[i])
			send_byte(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
		sent += text_buf.size();
	endtask

	// receiver
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h got 0x%0h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_tokens.size() == 0) begin
				$display("%0t: unexpected token kind %0d expected none", $time, m_tuser);
				fail_count++;
			end else begin
				want = pending_tokens.pop_front();
				check_field("kind", 32'(want.kind), 32'(m_tuser));
				check_field("char_byte", 32'(want.char_byte), 32'(m_tdata[TD_CHAR_LO +: 8]));
				check_field("int_value", want.int_value, m_tdata[TD_INT_LO +: 32]);
				check_field("frac_value", 32'(want.frac_value), 32'(m_tdata[TD_FRAC_LO +: 30]));
				check_field("frac_digits", 32'(want.frac_digits), 32'(m_tdata[TD_DIG_LO +: 4]));
				check_field("is_negative", 32'(want.is_negative), 32'(m_tdata[TD_NEG]));
				check_field("position", 32'(want.position), 32'(m_tdata[TD_POS_LO +: POS_BITS]));
				check_field("run_last", 32'(want.run_last), 32'(m_tlast));
			end
		end
	end

	initial begin
		int sent;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		reset_scanner();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 10;
		snk_idle_pct = 30;
		for (int i = 0; i < DIR_ROWS; i++)
			send_byte(dir_tab[i].b, dir_tab[i].l, dir_tab[i].fixed,
				make_token(dir_tab[i].kind, dir_tab[i].pos));
		s_tvalid <= 1'b0;
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 76 : 0;
			snk_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 20 : 0;
			// long receiver stall while the sender keeps offering bytes
			if (ph != 1)
				hold_left = 150;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				build_buffer();
				send_buffer(sent);
			end
			s_tvalid <= 1'b0;
			wait_drained();
		end

		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== flat_json_object_tokenizer.f =====
rtl/fjot_pkg.sv
rtl/fjot_step.sv
rtl/flat_json_object_tokenizer.sv
rtl/fjot_checker.sv
tb/tb_top.sv
